// ----- src/u16u8_pkg.sv -----
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
`timescale 1ns / 1ps

package u16u8_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [5:0]  LIMIT_RESET = 6'd60;
    localparam logic [5:0]  COUNT_MAX   = 6'd63;

    localparam logic [15:0] ONE_BYTE_END = 16'h0080;
    localparam logic [15:0] TWO_BYTE_END = 16'h0800;
    localparam logic [15:0] HI_SURR_LO   = 16'hD800;
    localparam logic [15:0] HI_SURR_HI   = 16'hDBFF;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;
    localparam logic [20:0] LO_SURR_BASE = 21'h0DC00;

    localparam logic [7:0]  LEAD2 = 8'hC0;
    localparam logic [7:0]  LEAD3 = 8'hE0;
    localparam logic [7:0]  LEAD4 = 8'hF0;
    localparam logic [7:0]  CONT  = 8'h80;
    localparam logic [7:0]  TERM_BYTE = 8'h00;

    // One code unit's worth of work for the serializer.
    typedef struct packed {
        logic [3:0][7:0] bytes;   // bytes[0] goes out first
        logic [2:0]      nbytes;  // character bytes, 0..4
        logic            eos;     // append the closing terminator byte
    } t_job;

endpackage

// ----- src/u16u8_front.sv -----
// Front end: accepts code units, tracks string state and builds byte jobs.
`timescale 1ns / 1ps

module u16u8_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [15:0]       i_code_unit,
    input  logic              i_end_of_string,
    input  logic              i_cfg_write,
    input  logic [5:0]        i_cfg_data,
    output logic              o_job_push,
    output u16u8_pkg::t_job   o_job
);

    logic [5:0]  r_byte_limit;
    logic        r_pend;
    logic [9:0]  r_pend_bits;
    logic [5:0]  r_count;
    logic        r_stopped;

    logic        n_pend;
    logic [9:0]  n_pend_bits;
    logic [5:0]  n_count;
    logic        n_stopped;

    logic [20:0] w_cp;
    logic        w_done_char;
    logic [6:0]  w_sum;
    logic [5:0]  w_sat;
    u16u8_pkg::t_job w_job;

    always_comb begin
        w_cp = u16u8_pkg::SUPP_BASE + {1'b0, r_pend_bits, 10'b0} + {5'b0, i_code_unit}
               - u16u8_pkg::LO_SURR_BASE;
    end

    always_comb begin
        w_job        = '0;
        w_job.eos    = i_end_of_string;
        w_done_char  = 1'b0;
        n_pend       = r_pend;
        n_pend_bits  = r_pend_bits;
        n_stopped    = r_stopped;
        if (!r_stopped) begin
            priority if (r_pend) begin
                w_job.bytes[0] = u16u8_pkg::LEAD4 | {5'b0, w_cp[20:18]};
                w_job.bytes[1] = u16u8_pkg::CONT | {2'b0, w_cp[17:12]};
                w_job.bytes[2] = u16u8_pkg::CONT | {2'b0, w_cp[11:6]};
                w_job.bytes[3] = u16u8_pkg::CONT | {2'b0, w_cp[5:0]};
                w_job.nbytes   = 3'd4;
                n_pend         = 1'b0;
                n_pend_bits    = '0;
                w_done_char    = 1'b1;
            end else if (i_code_unit == 16'h0000) begin
                n_stopped = 1'b1;
            end else if (i_code_unit < u16u8_pkg::ONE_BYTE_END) begin
                w_job.bytes[0] = i_code_unit[7:0];
                w_job.nbytes   = 3'd1;
                w_done_char    = 1'b1;
            end else if (i_code_unit < u16u8_pkg::TWO_BYTE_END) begin
                w_job.bytes[0] = u16u8_pkg::LEAD2 | {3'b0, i_code_unit[10:6]};
                w_job.bytes[1] = u16u8_pkg::CONT | {2'b0, i_code_unit[5:0]};
                w_job.nbytes   = 3'd2;
                w_done_char    = 1'b1;
            end else if (i_code_unit >= u16u8_pkg::HI_SURR_LO &&
                         i_code_unit <= u16u8_pkg::HI_SURR_HI) begin
                // hold the high half; a high half on the last unit is dropped
                if (!i_end_of_string) begin
                    n_pend      = 1'b1;
                    n_pend_bits = i_code_unit[9:0];
                end
            end else begin
                w_job.bytes[0] = u16u8_pkg::LEAD3 | {4'b0, i_code_unit[15:12]};
                w_job.bytes[1] = u16u8_pkg::CONT | {2'b0, i_code_unit[11:6]};
                w_job.bytes[2] = u16u8_pkg::CONT | {2'b0, i_code_unit[5:0]};
                w_job.nbytes   = 3'd3;
                w_done_char    = 1'b1;
            end
        end

        w_sum   = {1'b0, r_count} + {4'b0, w_job.nbytes};
        w_sat   = (w_sum > {1'b0, u16u8_pkg::COUNT_MAX}) ? u16u8_pkg::COUNT_MAX : w_sum[5:0];
        n_count = r_count;
        if (w_done_char) begin
            n_count = w_sat;
            if (w_sat >= r_byte_limit) begin
                n_stopped = 1'b1;
            end
        end

        // start the next string from a clean state
        if (i_end_of_string) begin
            n_pend      = 1'b0;
            n_pend_bits = '0;
            n_count     = '0;
            n_stopped   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_limit <= u16u8_pkg::LIMIT_RESET;
            r_pend       <= 1'b0;
            r_pend_bits  <= '0;
            r_count      <= '0;
            r_stopped    <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_byte_limit <= i_cfg_data;
            end
            if (i_accept) begin
                r_pend      <= n_pend;
                r_pend_bits <= n_pend_bits;
                r_count     <= n_count;
                r_stopped   <= n_stopped;
            end
        end
    end

    assign o_job      = w_job;
    assign o_job_push = i_accept && (w_job.nbytes != 3'd0 || w_job.eos);

endmodule

// ----- src/u16u8_fifo.sv -----
// Short job queue between the front end and the byte serializer.
`timescale 1ns / 1ps

module u16u8_fifo #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u16u8_pkg::t_job   i_data,
    output logic              o_full,
    input  logic              i_pop,
    output u16u8_pkg::t_job   o_data,
    output logic              o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    u16u8_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("job queue count out of range");

endmodule

// ----- src/u16u8_back.sv -----
// Back end: serializes queued jobs into one UTF-8 byte per cycle while bytes are popped.
`timescale 1ns / 1ps

module u16u8_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_avail,
    input  u16u8_pkg::t_job   i_job,
    output logic              o_job_take,
    output logic [7:0]        o_out_byte,
    output logic              o_last_of_string,
    output logic              o_empty,
    input  logic              i_pop
);

    u16u8_pkg::t_job r_job;
    logic            r_job_valid;
    logic [2:0]      r_idx;
    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic            r_out_last;

    logic [2:0] w_total;
    logic       w_take_out;
    logic       w_adv;
    logic       w_fin;
    logic       w_load;
    logic       w_is_term;
    logic [7:0] w_byte;

    assign w_total    = r_job.nbytes + {2'b0, r_job.eos};
    assign w_take_out = i_pop && r_out_valid;
    assign w_adv      = r_job_valid && (!r_out_valid || w_take_out);
    assign w_fin      = w_adv && (r_idx + 3'd1 == w_total);
    assign w_load     = i_job_avail && (!r_job_valid || w_fin);
    assign w_is_term  = (r_idx >= r_job.nbytes);
    assign w_byte     = w_is_term ? u16u8_pkg::TERM_BYTE : r_job.bytes[r_idx[1:0]];

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job <= i_job;
        end
        if (w_adv) begin
            r_out_byte <= w_byte;
            r_out_last <= w_is_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_job_valid <= 1'b1;
                r_idx       <= '0;
            end else if (w_fin) begin
                r_job_valid <= 1'b0;
                r_idx       <= '0;
            end else if (w_adv) begin
                r_idx <= r_idx + 3'd1;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (w_take_out) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_job_take       = w_load;
    assign o_out_byte       = r_out_byte;
    assign o_last_of_string = r_out_last;
    assign o_empty          = !r_out_valid;

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_idx < w_total))
        else $error("serializer index beyond job length");

    a_term_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_byte == u16u8_pkg::TERM_BYTE))
        else $error("closing byte is not zero");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out_byte)))
        else $error("stalled output byte changed");

endmodule

// ----- src/utf16_to_utf8_transcoder.sv -----
// Top level of the UTF-16 to UTF-8 transcoder.
`timescale 1ns / 1ps

// Code units enter through push/full and UTF-8 bytes leave through empty/pop, oldest
// first; the byte marked last is the 0x00 that closes each string. The front end takes
// one code unit per cycle while its job queue (QUEUE_DEPTH entries) has room, and the
// first byte of a unit passes through the job queue, the serializer's job register and
// its output register before it appears. The serializer emits one byte per cycle while
// the consumer keeps popping; a character gives one to four bytes, and the last unit of
// a string adds the closing byte. A unit that produces none, such as a held high
// surrogate or a unit past the stop point, still waits at the input while the queue is
// full. byte_limit is written through the cfg channel, which is always ready, and should
// change only while no string is in flight.
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_code_unit,
    input  logic        i_end_of_string,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_string,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data
);

    logic            w_accept;
    logic            w_job_push;
    u16u8_pkg::t_job w_job_in;
    u16u8_pkg::t_job w_job_out;
    logic            w_q_empty;
    logic            w_job_take;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = push && !full;

    u16u8_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_code_unit     (i_code_unit),
        .i_end_of_string (i_end_of_string),
        .i_cfg_write     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_job_push      (w_job_push),
        .o_job           (w_job_in)
    );

    u16u8_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (full),
        .i_pop   (w_job_take),
        .o_data  (w_job_out),
        .o_empty (w_q_empty)
    );

    u16u8_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_avail      (!w_q_empty),
        .i_job            (w_job_out),
        .o_job_take       (w_job_take),
        .o_out_byte       (o_out_byte),
        .o_last_of_string (o_last_of_string),
        .o_empty          (empty),
        .i_pop            (pop)
    );

endmodule
